@@ rtl/core/u8v_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the scalar range check for the utf-8 validator
package u8v_pkg;

  localparam int unsigned ScalarW = 21;

  // request kind codes
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  // continuation byte form 10xxxxxx
  localparam logic [1:0] CONT_TAG = 2'b10;

  // sequence lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_1    = 3'd1;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  // scalar limits
  localparam logic [ScalarW-1:0] SCALAR_MAX   = 21'h10FFFF;
  localparam logic [ScalarW-1:0] SURR_LO      = 21'h00D800;
  localparam logic [ScalarW-1:0] SURR_HI      = 21'h00DFFF;
  localparam logic [ScalarW-1:0] MIN_3BYTE    = 21'h000800;
  localparam logic [ScalarW-1:0] MIN_4BYTE    = 21'h010000;

  typedef struct packed {
    logic [1:0]         pending;
    logic [2:0]         seq_len;
    logic [ScalarW-1:0] partial;
    logic               err;
  } dec_state_t;

  function automatic logic scalar_bad(input logic [2:0] len, input logic [ScalarW-1:0] s);
    logic bad;
    bad = 1'b0;
    if (len == LEN_3 && s < MIN_3BYTE) bad = 1'b1;
    if (len == LEN_4 && s < MIN_4BYTE) bad = 1'b1;
    if (s > SCALAR_MAX) bad = 1'b1;
    if (s >= SURR_LO && s <= SURR_HI) bad = 1'b1;
    if (s == '0) bad = 1'b1;
    return bad;
  endfunction

endpackage

@@ rtl/core/u8v_decode.sv @@
`timescale 1ns / 1ps
// next decode state for one text byte
module u8v_decode
  import u8v_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  data_byte,
  output dec_state_t  nxt
);

  logic [ScalarW-1:0] shifted;

  assign shifted = {cur.partial[ScalarW-7:0], data_byte[5:0]};

  always_comb begin
    nxt = cur;
    if (!cur.err) begin
      if (cur.pending == 2'd0) begin
        if (!data_byte[7]) begin
          // single byte, only nul is refused
          if (scalar_bad(LEN_1, {13'd0, data_byte})) nxt.err = 1'b1;
        end else if (data_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
          nxt.seq_len = LEN_2;
          nxt.pending = 2'd1;
          nxt.partial = {16'd0, data_byte[4:0]};
        end else if (data_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
          nxt.seq_len = LEN_3;
          nxt.pending = 2'd2;
          nxt.partial = {17'd0, data_byte[3:0]};
        end else if (data_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
          nxt.seq_len = LEN_4;
          nxt.pending = 2'd3;
          nxt.partial = {18'd0, data_byte[2:0]};
        end else begin
          nxt.err = 1'b1;
        end
      end else if (data_byte[7:6] != CONT_TAG) begin
        nxt.err = 1'b1;
      end else begin
        nxt.pending = cur.pending - 2'd1;
        if (cur.pending == 2'd1) begin
          if (scalar_bad(cur.seq_len, shifted)) nxt.err = 1'b1;
          nxt.seq_len = LEN_NONE;
          nxt.partial = '0;
        end else begin
          nxt.partial = shifted;
        end
      end
    end
  end

endmodule

@@ rtl/core/utf8_stream_validator_core.sv @@
`timescale 1ns / 1ps
// top level of the streaming strict utf-8 validator
// an accepted end request passes through the input register, then its verdict is held in the result register
// throughput: one request per cycle, data and end requests alike, set by the byte decode
// a held verdict does not stop data requests; only an end request waits for the result register
// reset: synchronous active-high rst empties the input and result registers and clears
// the decode state, so the next text starts clean
module utf8_stream_validator_core
  import u8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       text_valid
);

  // input register
  logic       in_full;
  logic       kind_q;
  logic [7:0] byte_q;

  // decode state
  dec_state_t state;
  dec_state_t state_next;

  logic consume;
  logic end_take;

  // a data request always moves on; an end request needs the result register free
  assign consume  = in_full && (kind_q == KIND_DATA || !out_valid || out_ready);
  assign end_take = consume && kind_q == KIND_END;
  assign in_ready = !in_full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_q <= kind;
      byte_q <= data_byte;
    end
  end

  u8v_decode u_decode (
    .cur       (state),
    .data_byte (byte_q),
    .nxt       (state_next)
  );

  // state advances on data, clears after the verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (end_take) begin
      state <= '0;
    end else if (consume) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (end_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a text is good when nothing went wrong and no sequence is left open
  always_ff @(posedge clk) begin
    if (end_take) begin
      text_valid <= !state.err && state.pending == 2'd0;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_end : assert property (@(posedge clk) disable iff (rst)
    end_take |=> state == '0)
    else $error("decode state not cleared after end request");

  a_err_sticky : assert property (@(posedge clk) disable iff (rst)
    state.err && !end_take |=> state.err)
    else $error("error flag dropped before end request");

  a_len_open : assert property (@(posedge clk) disable iff (rst)
    state.pending != 2'd0 |->
      (state.seq_len == LEN_2 || state.seq_len == LEN_3 || state.seq_len == LEN_4))
    else $error("open sequence without a length");

  a_partial_idle : assert property (@(posedge clk) disable iff (rst)
    state.pending == 2'd0 |-> state.partial == '0 && state.seq_len == LEN_NONE)
    else $error("partial scalar left over between sequences");

  a_end_waits : assert property (@(posedge clk) disable iff (rst)
    in_full && kind_q == KIND_END && out_valid && !out_ready |-> !in_ready)
    else $error("end request taken over an unread verdict");
`endif

endmodule

@@ bench/tb_utf8_stream_validator_core.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the streaming strict utf-8 validator core
module tb_utf8_stream_validator_core;
  import u8v_pkg::*;

  // keeps its own copy of the decode state and the queue of verdicts still to come
  class text_verdict_board;
    logic [1:0]         conts_due;
    logic [2:0]         seq_bytes;
    logic [ScalarW-1:0] scalar_acc;
    logic               text_broken;
    logic               verdicts_due[$];
    int unsigned        failures;

    function new();
      failures = 0;
      clear_text();
    endfunction

    function void clear_text();
      conts_due   = 2'd0;
      seq_bytes   = LEN_NONE;
      scalar_acc  = '0;
      text_broken = 1'b0;
    endfunction

    // strict range rules applied to a completed sequence
    function bit scalar_rejected(logic [2:0] nbytes, logic [ScalarW-1:0] s);
      if (nbytes == LEN_3 && s < MIN_3BYTE) return 1'b1;
      if (nbytes == LEN_4 && s < MIN_4BYTE) return 1'b1;
      if (s > SCALAR_MAX) return 1'b1;
      if (s >= SURR_LO && s <= SURR_HI) return 1'b1;
      return s == '0;
    endfunction

    function void decode_byte(logic [7:0] b);
      if (conts_due == 2'd0) begin
        if (b <= 8'h7F) begin
          if (scalar_rejected(LEN_1, ScalarW'(b))) text_broken = 1'b1;
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          seq_bytes  = LEN_2;
          conts_due  = 2'd1;
          scalar_acc = ScalarW'(b[4:0]);
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          seq_bytes  = LEN_3;
          conts_due  = 2'd2;
          scalar_acc = ScalarW'(b[3:0]);
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          seq_bytes  = LEN_4;
          conts_due  = 2'd3;
          scalar_acc = ScalarW'(b[2:0]);
        end else begin
          text_broken = 1'b1;
        end
      end else if (b[7:6] != CONT_TAG) begin
        text_broken = 1'b1;
      end else begin
        scalar_acc = {scalar_acc[ScalarW-7:0], b[5:0]};
        conts_due  = conts_due - 2'd1;
        if (conts_due == 2'd0) begin
          if (scalar_rejected(seq_bytes, scalar_acc)) text_broken = 1'b1;
          seq_bytes  = LEN_NONE;
          scalar_acc = '0;
        end
      end
    endfunction

    function void note_request(logic k, logic [7:0] b);
      if (k == KIND_END) begin
        verdicts_due.push_back(!text_broken && conts_due == 2'd0);
        clear_text();
      end else if (!text_broken) begin
        // once broken the text is frozen until its end request
        decode_byte(b);
      end
    endfunction

    function void check_verdict(logic got);
      logic want;
      if (verdicts_due.size() == 0) begin
        $error("text_valid: no verdict expected, actual %0b", got);
        failures++;
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) begin
          $error("text_valid: expected %0b, actual %0b", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  localparam int unsigned RandomItems = 1150;
  localparam int unsigned CycleLimit  = 400000;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_ready;
  logic       text_valid;

  text_verdict_board verdicts = new();

  logic [7:0]  text_bytes[$];
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  bit          steady     = 1'b0;

  utf8_stream_validator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_valid(text_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: ends the run if the traffic ever locks up
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // result side: sample on the edge, then pick the next ready level
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) verdicts.check_verdict(text_valid);
      out_ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  // one request, with a random run of idle cycles in front of it
  task automatic push_request(input logic k, input logic [7:0] b);
    steady = (items_sent >= 500 && items_sent < 800);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    verdicts.note_request(k, b);
    items_sent++;
  endtask

  // data requests for the queued bytes, closed by an end request with a junk byte
  task automatic send_text();
    foreach (text_bytes[i]) push_request(KIND_DATA, text_bytes[i]);
    push_request(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // hold the sender off until every verdict is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdicts.verdicts_due.size() != 0) @(posedge clk);
  endtask

  // raw encoder: no range check, so overlong and out-of-range forms come out too
  function automatic void encode_scalar(int unsigned nbytes, logic [20:0] s);
    case (nbytes)
      1: text_bytes.push_back(s[7:0]);
      2: begin
        text_bytes.push_back({3'b110, s[10:6]});
        text_bytes.push_back({2'b10, s[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, s[15:12]});
        text_bytes.push_back({2'b10, s[11:6]});
        text_bytes.push_back({2'b10, s[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, s[20:18]});
        text_bytes.push_back({2'b10, s[17:12]});
        text_bytes.push_back({2'b10, s[11:6]});
        text_bytes.push_back({2'b10, s[5:0]});
      end
    endcase
  endfunction

  function automatic void add_good_char();
    int unsigned pick;
    logic [20:0] s;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      encode_scalar(1, 21'($urandom_range(1, 'h7F)));
    end else if (pick < 6) begin
      encode_scalar(2, 21'($urandom_range('h80, 'h7FF)));
    end else if (pick < 8) begin
      s = 21'($urandom_range('h800, 'hFFFF));
      // steer clear of the surrogate block here
      if (s >= SURR_LO && s <= SURR_HI) s = s - 21'h800;
      encode_scalar(3, s);
    end else begin
      encode_scalar(4, 21'($urandom_range('h10000, 'h10FFFF)));
    end
  endfunction

  function automatic void add_flaw();
    int unsigned nbytes;
    int unsigned cut;
    case ($urandom_range(0, 7))
      0: text_bytes.push_back(8'h00);
      1: encode_scalar(3, 21'($urandom_range(0, 'h7FF)));
      2: encode_scalar(4, 21'($urandom_range(0, 'hFFFF)));
      3: encode_scalar(4, 21'($urandom_range('h110000, 'h13FFFF)));
      4: encode_scalar(3, 21'($urandom_range('hD800, 'hDFFF)));
      5: text_bytes.push_back(8'($urandom_range(0, 255)));
      6: begin
        // stray continuation, C0/C1, or F5 and above in lead position
        if ($urandom_range(0, 1) == 0) text_bytes.push_back(8'($urandom_range('h80, 'hC1)));
        else text_bytes.push_back(8'($urandom_range('hF5, 'hFF)));
      end
      default: begin
        // sequence cut short, in the middle or at the tail of the text
        nbytes = $urandom_range(2, 4);
        encode_scalar(nbytes, 21'($urandom_range(0, 'h1FFFFF)));
        cut = $urandom_range(1, nbytes - 1);
        repeat (cut) void'(text_bytes.pop_back());
      end
    endcase
  endfunction

  // mostly well-formed texts, a share with one flaw, a few of pure noise
  function automatic void build_random_text();
    int unsigned shape;
    int unsigned nchars;
    int unsigned flaw_at;
    text_bytes.delete();
    shape   = $urandom_range(0, 99);
    nchars  = $urandom_range(0, 10);
    flaw_at = (shape >= 70) ? $urandom_range(0, nchars) : nchars + 1;
    if (shape < 8) begin
      repeat ($urandom_range(1, 8)) text_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int unsigned i = 0; i < nchars; i++) begin
        if (i == flaw_at) add_flaw();
        add_good_char();
      end
      if (flaw_at == nchars) add_flaw();
    end
  endfunction

  initial begin
    int unsigned base;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    kind      <= KIND_DATA;
    data_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty text
    text_bytes.delete();
    send_text();
    // lone nul
    text_bytes = {8'h00};
    send_text();
    // top of ascii and the highest legal scalar
    text_bytes = {8'h7F, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    // overlong three-byte form
    text_bytes = {8'hE0, 8'h9F, 8'hBF};
    send_text();
    // overlong four-byte form
    text_bytes = {8'hF0, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    // just past the top of the code space
    text_bytes = {8'hF4, 8'h90, 8'h80, 8'h80};
    send_text();
    // low edge of the surrogate block
    text_bytes = {8'hED, 8'hA0, 8'h80};
    send_text();
    // bad lead, then a byte that must be ignored
    text_bytes = {8'hC1, 8'h41};
    send_text();
    // lead followed by ascii instead of a continuation
    text_bytes = {8'hC2, 8'h41};
    send_text();
    // sequence cut off by the end request
    text_bytes = {8'hE0, 8'hA0};
    send_text();

    wait_drained();

    base = items_sent;
    while (items_sent < base + RandomItems) begin
      build_random_text();
      send_text();
      if ($urandom_range(0, 99) < 3) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    if (verdicts.failures == 0 && verdicts.verdicts_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/u8v_pkg.sv
rtl/core/u8v_decode.sv
rtl/core/utf8_stream_validator_core.sv
bench/tb_utf8_stream_validator_core.sv
